[rtl/omx_pkg.sv]
package omx_pkg;

   // Default fraction width of the sine and cosine tables.
   localparam int TRIG_FRAC_BITS_DEF = 15;

   // Datapath widths.
   localparam int VQ_W     = 18;  // signed Q16 values within about +/-1.8
   localparam int SUM_W    = 20;  // signed wheel sums before the divide by three
   localparam int ABS_W    = 19;  // magnitude of a wheel sum plus one
   localparam int MAG_W    = 17;  // wheel drive magnitude in Q16
   localparam int SPD_W    = 7;
   localparam int SPD255_W = 15;
   localparam int NUM_W    = 32;  // speed * 255 * magnitude
   localparam int DEN_W    = 24;  // largest magnitude * 100
   localparam int QUO_W    = 9;   // quotient never exceeds 127 * 255 / 100
   localparam int MOTORS   = 3;
   localparam int DIR_W    = 2 * MOTORS;

   // Constants of the mix.
   localparam int SQRT3_Q16  = 113512;
   localparam int RECIP3_K   = 349526;  // ceil(2^20 / 3)
   localparam int RECIP3_SH  = 20;
   localparam int PCT_SCALE  = 100;
   localparam int FULL_BYTE  = 255;

   // Cycles from the accepting edge to the edge that takes the result word.
   localparam int RSP_LATENCY = 16;

   localparam longint Q30_ONE     = 64'sd1 << 30;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef logic signed [VQ_W-1:0] vq_type;
   typedef vq_type trig_tab_type [512];
   typedef logic [7:0] byte_tab_type [256];

   // Flags that travel with every word through the pipeline.
   typedef struct packed {
      logic       valid;
      logic       stop;
      logic       zero;
      logic [7:0] zmag;
      logic [DIR_W-1:0] zdir;
   } side_type;

   // Word handed from the mixing front end to the divider.
   typedef struct packed {
      side_type                      side;
      logic [MOTORS-1:0][NUM_W-1:0]  num;
      logic [DEN_W-1:0]              den;
      logic [DIR_W-1:0]              dir;
      logic                          ezero;
   } div_in_type;

   // Rounded shift right, ties away from zero.
   function automatic longint omx_rshift(longint n, int s);
      longint m;
      longint q;
      m = (n < 0) ? -n : n;
      q = (s > 0) ? ((m + (64'sd1 <<< (s - 1))) >>> s) : m;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint omx_mulq30(longint x, longint y);
      return (x * y + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // Divide a Taylor series term by k * (k + 1), for k from 1 to 28.
   function automatic longint omx_div_series(longint x, int k);
      case (k)
         1:  return x / 2;
         2:  return x / 6;
         3:  return x / 12;
         4:  return x / 20;
         5:  return x / 30;
         6:  return x / 42;
         7:  return x / 56;
         8:  return x / 72;
         9:  return x / 90;
         10: return x / 110;
         11: return x / 132;
         12: return x / 156;
         13: return x / 182;
         14: return x / 210;
         15: return x / 240;
         16: return x / 272;
         17: return x / 306;
         18: return x / 342;
         19: return x / 380;
         20: return x / 420;
         21: return x / 462;
         22: return x / 506;
         23: return x / 552;
         24: return x / 600;
         25: return x / 650;
         26: return x / 702;
         27: return x / 756;
         28: return x / 812;
         default: return 64'sd0;
      endcase
   endfunction

   // Sine or cosine of a heading code, in Q16, through Q1.tfb.
   function automatic longint omx_trig_q16(int code, int tfb, bit want_cos);
      longint head;
      longint t;
      longint num;
      longint a;
      longint ts;
      longint tc;
      longint ss;
      longint cs;
      longint v;
      longint vf;
      bit     neg_t;
      bit     flip;
      head = (code >= 256) ? longint'(code) - 512 : longint'(code);
      num  = (90 - head) * 314 * Q30_ONE;
      t    = (((num < 0) ? -num : num) + 9000) / 18000;
      if (num < 0) t = -t;
      if (t > PI_Q30) t = t - 2 * PI_Q30;
      if (t < -PI_Q30) t = t + 2 * PI_Q30;
      neg_t = (t < 0);
      a     = neg_t ? -t : t;
      flip  = (a > HALF_PI_Q30);
      if (flip) a = PI_Q30 - a;
      ts = a;
      tc = Q30_ONE;
      ss = a;
      cs = Q30_ONE;
      for (int n = 1; n <= 14; n++) begin
         ts = omx_div_series(omx_mulq30(omx_mulq30(ts, a), a), 2 * n);
         tc = omx_div_series(omx_mulq30(omx_mulq30(tc, a), a), 2 * n - 1);
         if ((n % 2) == 1) begin
            ss = ss - ts;
            cs = cs - tc;
         end else begin
            ss = ss + ts;
            cs = cs + tc;
         end
      end
      if (flip) cs = -cs;
      if (neg_t) ss = -ss;
      v  = want_cos ? cs : ss;
      vf = omx_rshift(v, 30 - tfb);
      if (tfb >= 16) return omx_rshift(vf, tfb - 16);
      return vf * (64'sd1 <<< (16 - tfb));
   endfunction

   function automatic trig_tab_type omx_trig_tab(int tfb, bit want_cos);
      trig_tab_type tab;
      for (int i = 0; i < 512; i++) begin
         tab[i] = VQ_W'(omx_trig_q16(i, tfb, want_cos));
      end
      return tab;
   endfunction

   // Rotation in Q16: rot * 65536 / 100, rounded.
   function automatic trig_tab_type omx_r16_tab();
      trig_tab_type tab;
      longint rot;
      longint m;
      for (int i = 0; i < 512; i++) begin
         rot = longint'(i % 256);
         if (rot >= 128) rot = rot - 256;
         m = ((((rot < 0) ? -rot : rot) * 65536) + 50) / 100;
         tab[i] = VQ_W'((rot < 0) ? -m : m);
      end
      return tab;
   endfunction

   // Zero-speed magnitude: |rot| * 255 / 100, saturated.
   function automatic byte_tab_type omx_zmag_tab();
      byte_tab_type tab;
      longint rot;
      longint m;
      for (int i = 0; i < 256; i++) begin
         rot = longint'(i);
         if (rot >= 128) rot = rot - 256;
         m = (((rot < 0) ? -rot : rot) * 255) / 100;
         tab[i] = (m > 255) ? 8'd255 : 8'(m);
      end
      return tab;
   endfunction

endpackage

[rtl/omx_front.sv]
module omx_front #(
   parameter int TRIG_FRAC_BITS = omx_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          full_stop,
   input  logic [omx_pkg::SPD_W-1:0]     speed_percent,
   input  logic signed [8:0]             heading_deg,
   input  logic signed [7:0]             rotation_percent,
   output omx_pkg::div_in_type           div_in
);
   import omx_pkg::*;

   localparam trig_tab_type VX_TAB   = omx_trig_tab(TRIG_FRAC_BITS, 1'b0);
   localparam trig_tab_type VY_TAB   = omx_trig_tab(TRIG_FRAC_BITS, 1'b1);
   localparam trig_tab_type R16_TAB  = omx_r16_tab();
   localparam byte_tab_type ZMAG_TAB = omx_zmag_tab();

   // Stage 1: table lookups and bypass flags.
   side_type   s1_side_ff, s1_side_in;
   vq_type     s1_vx_ff, s1_vy_ff, s1_r16_ff;
   logic [SPD_W-1:0] s1_spd_ff;

   always_comb begin
      s1_side_in.valid = accept;
      s1_side_in.stop  = full_stop;
      s1_side_in.zero  = (speed_percent == '0);
      s1_side_in.zmag  = ZMAG_TAB[$unsigned(rotation_percent)];
      if (rotation_percent > 0) begin
         s1_side_in.zdir = 6'b010101;
      end else if (rotation_percent < 0) begin
         s1_side_in.zdir = 6'b101010;
      end else begin
         s1_side_in.zdir = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
      end else begin
         s1_side_ff.valid <= s1_side_in.valid;
      end
      s1_side_ff.stop <= s1_side_in.stop;
      s1_side_ff.zero <= s1_side_in.zero;
      s1_side_ff.zmag <= s1_side_in.zmag;
      s1_side_ff.zdir <= s1_side_in.zdir;
      s1_vx_ff  <= VX_TAB[$unsigned(heading_deg)];
      s1_vy_ff  <= VY_TAB[$unsigned(heading_deg)];
      s1_r16_ff <= R16_TAB[{1'b0, $unsigned(rotation_percent)}];
      s1_spd_ff <= speed_percent;
   end

   // Stage 2: vx * sqrt(3), rounded back to Q16.
   side_type   s2_side_ff;
   vq_type     s2_sq_ff, s2_sq_in, s2_vy_ff, s2_r16_ff;
   logic [SPD255_W-1:0] s2_spd255_ff;
   logic signed [35:0]  s2_prod;
   logic [35:0]         s2_pmag;
   logic [35:0]         s2_rnd;

   always_comb begin
      s2_prod  = 36'(s1_vx_ff) * 36'sd113512;
      s2_pmag  = s2_prod[35] ? 36'($unsigned(-s2_prod)) : 36'($unsigned(s2_prod));
      s2_rnd   = s2_pmag + 36'd32768;
      s2_sq_in = s2_prod[35] ? -$signed({1'b0, s2_rnd[32:16]})
                             : $signed({1'b0, s2_rnd[32:16]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff.valid <= 1'b0;
      end else begin
         s2_side_ff.valid <= s1_side_ff.valid;
      end
      s2_side_ff.stop <= s1_side_ff.stop;
      s2_side_ff.zero <= s1_side_ff.zero;
      s2_side_ff.zmag <= s1_side_ff.zmag;
      s2_side_ff.zdir <= s1_side_ff.zdir;
      s2_sq_ff     <= s2_sq_in;
      s2_vy_ff     <= s1_vy_ff;
      s2_r16_ff    <= s1_r16_ff;
      s2_spd255_ff <= {s1_spd_ff, 8'd0} - SPD255_W'(s1_spd_ff);
   end

   // Stage 3: the three wheel sums, as magnitude plus one and sign.
   side_type   s3_side_ff;
   logic [MOTORS-1:0][ABS_W-1:0] s3_x_ff, s3_x_in;
   logic [MOTORS-1:0]            s3_neg_ff, s3_neg_in;
   logic [SPD255_W-1:0]          s3_spd255_ff;
   logic signed [SUM_W-1:0]      s3_n [MOTORS];
   logic [SUM_W-1:0]             s3_abs;

   always_comb begin
      s3_n[0] = SUM_W'(s2_vy_ff) - SUM_W'(s2_sq_ff) + SUM_W'(s2_r16_ff);
      s3_n[1] = SUM_W'(s2_r16_ff) - (SUM_W'(s2_vy_ff) <<< 1);
      s3_n[2] = SUM_W'(s2_vy_ff) + SUM_W'(s2_sq_ff) + SUM_W'(s2_r16_ff);
      s3_abs  = '0;
      for (int k = 0; k < MOTORS; k++) begin
         s3_abs       = s3_n[k][SUM_W-1] ? $unsigned(-s3_n[k]) : $unsigned(s3_n[k]);
         s3_abs       = s3_abs + 1'b1;
         s3_x_in[k]   = s3_abs[ABS_W-1:0];
         s3_neg_in[k] = s3_n[k][SUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.valid <= 1'b0;
      end else begin
         s3_side_ff.valid <= s2_side_ff.valid;
      end
      s3_side_ff.stop <= s2_side_ff.stop;
      s3_side_ff.zero <= s2_side_ff.zero;
      s3_side_ff.zmag <= s2_side_ff.zmag;
      s3_side_ff.zdir <= s2_side_ff.zdir;
      s3_x_ff      <= s3_x_in;
      s3_neg_ff    <= s3_neg_in;
      s3_spd255_ff <= s2_spd255_ff;
   end

   // Stage 4: rounded divide by three through a reciprocal product.
   side_type   s4_side_ff;
   logic [MOTORS-1:0][MAG_W-1:0] s4_mag_ff, s4_mag_in;
   logic [MOTORS-1:0]            s4_neg_ff;
   logic [SPD255_W-1:0]          s4_spd255_ff;
   logic [37:0]                  s4_prod;

   always_comb begin
      s4_prod = '0;
      for (int k = 0; k < MOTORS; k++) begin
         s4_prod      = 38'(s3_x_ff[k]) * 38'(RECIP3_K);
         s4_mag_in[k] = s4_prod[RECIP3_SH+MAG_W-1:RECIP3_SH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff.valid <= 1'b0;
      end else begin
         s4_side_ff.valid <= s3_side_ff.valid;
      end
      s4_side_ff.stop <= s3_side_ff.stop;
      s4_side_ff.zero <= s3_side_ff.zero;
      s4_side_ff.zmag <= s3_side_ff.zmag;
      s4_side_ff.zdir <= s3_side_ff.zdir;
      s4_mag_ff    <= s4_mag_in;
      s4_neg_ff    <= s3_neg_ff;
      s4_spd255_ff <= s3_spd255_ff;
   end

   // Stage 5: largest magnitude, numerators and direction bits.
   side_type   s5_side_ff;
   logic [MAG_W-1:0]             s5_e_ff, s5_e_in;
   logic [MOTORS-1:0][NUM_W-1:0] s5_num_ff, s5_num_in;
   logic [DIR_W-1:0]             s5_dir_ff, s5_dir_in;

   always_comb begin
      s5_e_in = '0;
      for (int k = 0; k < MOTORS; k++) begin
         if (s4_mag_ff[k] > s5_e_in) s5_e_in = s4_mag_ff[k];
         s5_num_in[k]       = NUM_W'(s4_spd255_ff) * NUM_W'(s4_mag_ff[k]);
         s5_dir_in[2*k]     = (s4_mag_ff[k] != '0) && !s4_neg_ff[k];
         s5_dir_in[2*k+1]   = (s4_mag_ff[k] != '0) && s4_neg_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff.valid <= 1'b0;
      end else begin
         s5_side_ff.valid <= s4_side_ff.valid;
      end
      s5_side_ff.stop <= s4_side_ff.stop;
      s5_side_ff.zero <= s4_side_ff.zero;
      s5_side_ff.zmag <= s4_side_ff.zmag;
      s5_side_ff.zdir <= s4_side_ff.zdir;
      s5_e_ff   <= s5_e_in;
      s5_num_ff <= s5_num_in;
      s5_dir_ff <= s5_dir_in;
   end

   // Stage 6: divisor for the normalizing divide.
   div_in_type s6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ff.side.valid <= 1'b0;
      end else begin
         s6_ff.side.valid <= s5_side_ff.valid;
      end
      s6_ff.side.stop <= s5_side_ff.stop;
      s6_ff.side.zero <= s5_side_ff.zero;
      s6_ff.side.zmag <= s5_side_ff.zmag;
      s6_ff.side.zdir <= s5_side_ff.zdir;
      s6_ff.num   <= s5_num_ff;
      s6_ff.den   <= DEN_W'(s5_e_ff) * DEN_W'(PCT_SCALE);
      s6_ff.dir   <= s5_dir_ff;
      s6_ff.ezero <= (s5_e_ff == '0);
   end

   assign div_in = s6_ff;

endmodule

[rtl/omx_divider.sv]
module omx_divider (
   input  logic                                             clock,
   input  logic                                             reset,
   input  omx_pkg::div_in_type                              div_in,
   output omx_pkg::side_type                                side_out,
   output logic [omx_pkg::MOTORS-1:0][omx_pkg::QUO_W-1:0]   quo_out,
   output logic [omx_pkg::DIR_W-1:0]                        dir_out,
   output logic                                             ezero_out
);
   import omx_pkg::*;

   // One quotient bit per stage, most significant first, for all wheels.
   div_in_type                   stg_ff [QUO_W];
   logic [MOTORS-1:0][QUO_W-1:0] quo_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int BIT = QUO_W - 1 - j;

      div_in_type                   prev;
      logic [MOTORS-1:0][QUO_W-1:0] prev_quo;
      div_in_type                   nxt;
      logic [MOTORS-1:0][QUO_W-1:0] nxt_quo;
      logic [NUM_W:0]               shifted;
      logic [NUM_W:0]               rem;

      if (j == 0) begin : g_first
         assign prev     = div_in;
         assign prev_quo = '0;
      end else begin : g_rest
         assign prev     = stg_ff[j-1];
         assign prev_quo = quo_ff[j-1];
      end

      // Trial subtract of the shifted divisor from each remainder.
      always_comb begin
         nxt     = prev;
         nxt_quo = prev_quo;
         shifted = (NUM_W+1)'(prev.den) << BIT;
         rem     = '0;
         for (int k = 0; k < MOTORS; k++) begin
            rem = {1'b0, prev.num[k]};
            if (rem >= shifted) begin
               nxt.num[k]      = NUM_W'(rem - shifted);
               nxt_quo[k][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[j].side.valid <= 1'b0;
         end else begin
            stg_ff[j].side.valid <= nxt.side.valid;
         end
         stg_ff[j].side.stop <= nxt.side.stop;
         stg_ff[j].side.zero <= nxt.side.zero;
         stg_ff[j].side.zmag <= nxt.side.zmag;
         stg_ff[j].side.zdir <= nxt.side.zdir;
         stg_ff[j].num   <= nxt.num;
         stg_ff[j].den   <= nxt.den;
         stg_ff[j].dir   <= nxt.dir;
         stg_ff[j].ezero <= nxt.ezero;
         quo_ff[j]       <= nxt_quo;
      end
   end

   assign side_out  = stg_ff[QUO_W-1].side;
   assign quo_out   = quo_ff[QUO_W-1];
   assign dir_out   = stg_ff[QUO_W-1].dir;
   assign ezero_out = stg_ff[QUO_W-1].ezero;

endmodule

[rtl/three_wheel_omni_motor_mixer_top.sv]
// Three-wheel omni drive mixer.
// A command word (stop flag, speed percent, heading in degrees, signed
// rotation percent) is accepted at a rising edge where start is high and
// busy is low. Busy stays low: a new command may be given in every cycle.
// Each command yields one result word: three wheel magnitudes, a fourth
// magnitude and a direction byte, shown on the rsp_ ports for exactly one
// cycle while rsp_valid is high.
// Six mixing stages (table lookup, sqrt(3) product, wheel sums, divide by
// three, maximum, divisor) are followed by a nine-stage restoring divider,
// one quotient bit per stage, and the output register. Throughput is one
// command per cycle. A synchronous reset clears all valid bits; commands in
// flight are dropped and no result word appears for them.
// The receiver cannot stall: every result word is taken in its cycle.
module three_wheel_omni_motor_mixer_top #(
   parameter int TRIG_FRAC_BITS = omx_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_full_stop,
   input  logic [6:0]                req_speed_percent,
   input  logic signed [8:0]         req_heading_deg,
   input  logic signed [7:0]         req_rotation_percent,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_motor1_mag,
   output logic [7:0]                rsp_motor2_mag,
   output logic [7:0]                rsp_motor3_mag,
   output logic [7:0]                rsp_motor4_mag,
   output logic [7:0]                rsp_direction_bits
);
   import omx_pkg::*;

   logic                          accept;
   div_in_type                    div_in;
   side_type                      side;
   logic [MOTORS-1:0][QUO_W-1:0]  quo;
   logic [DIR_W-1:0]              dir;
   logic                          ezero;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   omx_front #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .full_stop        (req_full_stop),
      .speed_percent    (req_speed_percent),
      .heading_deg      (req_heading_deg),
      .rotation_percent (req_rotation_percent),
      .div_in           (div_in)
   );

   omx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_in    (div_in),
      .side_out  (side),
      .quo_out   (quo),
      .dir_out   (dir),
      .ezero_out (ezero)
   );

   // Output selection: stop frame, zero-speed spin, or normalized mix.
   logic               valid_ff;
   logic [7:0]         mag_ff [4];
   logic [7:0]         mag_in [4];
   logic [7:0]         dir_ff, dir_in;

   always_comb begin
      for (int k = 0; k < MOTORS; k++) begin
         if (ezero) begin
            mag_in[k] = '0;
         end else if (quo[k] > QUO_W'(FULL_BYTE)) begin
            mag_in[k] = 8'(FULL_BYTE);
         end else begin
            mag_in[k] = quo[k][7:0];
         end
      end
      mag_in[3] = '0;
      dir_in    = ezero ? 8'd0 : {2'b00, dir};
      if (side.stop) begin
         for (int k = 0; k < 4; k++) begin
            mag_in[k] = 8'(FULL_BYTE);
         end
         dir_in = 8'(FULL_BYTE);
      end else if (side.zero) begin
         for (int k = 0; k < MOTORS; k++) begin
            mag_in[k] = side.zmag;
         end
         dir_in = {2'b00, side.zdir};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= side.valid;
      end
      for (int k = 0; k < 4; k++) begin
         mag_ff[k] <= mag_in[k];
      end
      dir_ff <= dir_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_motor1_mag     = mag_ff[0];
   assign rsp_motor2_mag     = mag_ff[1];
   assign rsp_motor3_mag     = mag_ff[2];
   assign rsp_motor4_mag     = mag_ff[3];
   assign rsp_direction_bits = dir_ff;

endmodule

[rtl/omx_checker.sv]
module omx_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_full_stop,
   input logic       rsp_valid,
   input logic [7:0] rsp_motor4_mag,
   input logic [7:0] rsp_direction_bits
);
   import omx_pkg::*;

   // Every accepted command gives a result word after the fixed latency.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("result word missing after accepted command");

   // No result word appears without a command accepted before it.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result word without accepted command");

   // A stop command yields the stop frame.
   a_stop_frame : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_full_stop) |->
         ##RSP_LATENCY (rsp_motor4_mag == 8'd255 && rsp_direction_bits == 8'd255))
      else $error("stop command did not give stop frame");

   // The fourth motor is only ever off or full.
   a_motor4 : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_motor4_mag == 8'd0 || rsp_motor4_mag == 8'd255))
      else $error("fourth motor magnitude out of set");

endmodule

bind three_wheel_omni_motor_mixer_top omx_checker u_omx_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_full_stop      (req_full_stop),
   .rsp_valid          (rsp_valid),
   .rsp_motor4_mag     (rsp_motor4_mag),
   .rsp_direction_bits (rsp_direction_bits)
);
